@@ rtl/polygon_plane_side_classifier_unit_assert.svh @@
// assertion macros for the polygon plane side classifier
// used by the top level; no other dependencies
`ifndef POLYGON_PLANE_SIDE_CLASSIFIER_UNIT_ASSERT_SVH
`define POLYGON_PLANE_SIDE_CLASSIFIER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PPSC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppsc implication check failed");

// condition holds at every clock edge
`define PPSC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ppsc invariant check failed");

`endif

@@ rtl/ppsc_pkg.sv @@
// shared types, codes and reset values of the polygon plane side classifier
// no dependencies
`timescale 1ns / 1ps

package ppsc_pkg;

   localparam int DIST_W = 40;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // register indexes
   localparam logic [2:0] REG_NORMAL_X   = 3'd0;
   localparam logic [2:0] REG_NORMAL_Y   = 3'd1;
   localparam logic [2:0] REG_NORMAL_Z   = 3'd2;
   localparam logic [2:0] REG_OFFSET     = 3'd3;
   localparam logic [2:0] REG_KIND       = 3'd4;
   localparam logic [2:0] REG_CHOP       = 3'd5;
   localparam logic [2:0] REG_MIN_SPLIT  = 3'd6;
   localparam logic [2:0] REG_MAX_SPLIT  = 3'd7;

   // plane kinds
   localparam logic [1:0] KIND_AXIAL_X = 2'd0;
   localparam logic [1:0] KIND_AXIAL_Y = 2'd1;
   localparam logic [1:0] KIND_AXIAL_Z = 2'd2;
   localparam logic [1:0] KIND_SLOPED  = 2'd3;

   // side codes
   localparam logic [1:0] SIDE_AHEAD  = 2'd0;
   localparam logic [1:0] SIDE_BEHIND = 2'd1;
   localparam logic [1:0] SIDE_CROSS  = 2'd2;

   // reset values
   localparam logic [31:0] RST_NORMAL_X  = 32'h4000_0000;
   localparam logic [31:0] RST_NORMAL_Y  = 32'h0;
   localparam logic [31:0] RST_NORMAL_Z  = 32'h0;
   localparam logic [31:0] RST_OFFSET    = 32'h0;
   localparam logic [1:0]  RST_KIND      = KIND_SLOPED;
   localparam logic [30:0] RST_CHOP      = 31'd4;
   localparam logic [30:0] RST_MIN_SPLIT = 31'd4;
   localparam logic [30:0] RST_MAX_SPLIT = 31'd4096;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic [1:0] side;
      logic       near_split;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic signed [31:0] plane_offset;
      logic [1:0]         plane_kind;
      logic [30:0]        chop_margin;
      logic [30:0]        min_split_margin;
      logic [30:0]        max_split_margin;
   } cfg_type;

   typedef struct packed {
      logic signed [DIST_W-1:0] distance;
      logic                     last_point;
   } entry_type;

   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
   } front_status_type;

endpackage

@@ rtl/ppsc_csr.sv @@
// apb-style configuration registers of the classifier
// depends on ppsc_pkg
`timescale 1ns / 1ps

module ppsc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ppsc_pkg::ADDR_W-1:0]  paddr,
   input  logic [ppsc_pkg::DATA_W-1:0]  pwdata,
   output logic [ppsc_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output ppsc_pkg::cfg_type            cfg
);

   ppsc_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [2:0]        reg_sel;

   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[4:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            ppsc_pkg::REG_NORMAL_X:  cfg_in.normal_x         = pwdata;
            ppsc_pkg::REG_NORMAL_Y:  cfg_in.normal_y         = pwdata;
            ppsc_pkg::REG_NORMAL_Z:  cfg_in.normal_z         = pwdata;
            ppsc_pkg::REG_OFFSET:    cfg_in.plane_offset     = pwdata;
            ppsc_pkg::REG_KIND:      cfg_in.plane_kind       = pwdata[1:0];
            ppsc_pkg::REG_CHOP:      cfg_in.chop_margin      = pwdata[30:0];
            ppsc_pkg::REG_MIN_SPLIT: cfg_in.min_split_margin = pwdata[30:0];
            ppsc_pkg::REG_MAX_SPLIT: cfg_in.max_split_margin = pwdata[30:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         ppsc_pkg::REG_NORMAL_X:  prdata = cfg_ff.normal_x;
         ppsc_pkg::REG_NORMAL_Y:  prdata = cfg_ff.normal_y;
         ppsc_pkg::REG_NORMAL_Z:  prdata = cfg_ff.normal_z;
         ppsc_pkg::REG_OFFSET:    prdata = cfg_ff.plane_offset;
         ppsc_pkg::REG_KIND:      prdata = {30'd0, cfg_ff.plane_kind};
         ppsc_pkg::REG_CHOP:      prdata = {1'b0, cfg_ff.chop_margin};
         ppsc_pkg::REG_MIN_SPLIT: prdata = {1'b0, cfg_ff.min_split_margin};
         ppsc_pkg::REG_MAX_SPLIT: prdata = {1'b0, cfg_ff.max_split_margin};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal_x         <= ppsc_pkg::RST_NORMAL_X;
         cfg_ff.normal_y         <= ppsc_pkg::RST_NORMAL_Y;
         cfg_ff.normal_z         <= ppsc_pkg::RST_NORMAL_Z;
         cfg_ff.plane_offset     <= ppsc_pkg::RST_OFFSET;
         cfg_ff.plane_kind       <= ppsc_pkg::RST_KIND;
         cfg_ff.chop_margin      <= ppsc_pkg::RST_CHOP;
         cfg_ff.min_split_margin <= ppsc_pkg::RST_MIN_SPLIT;
         cfg_ff.max_split_margin <= ppsc_pkg::RST_MAX_SPLIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/ppsc_front.sv @@
// front part: two-stage signed distance pipeline (products, then sum)
// depends on ppsc_pkg
`timescale 1ns / 1ps

module ppsc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  ppsc_pkg::req_type           req,
   input  ppsc_pkg::cfg_type           cfg,
   output logic                        push,
   output ppsc_pkg::entry_type         push_entry,
   output ppsc_pkg::front_status_type  status
);

   // stage 1: products and the axial coordinate
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_last_ff;
   logic signed [63:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [63:0]  prod_x_in, prod_y_in, prod_z_in;
   logic signed [31:0]  axial_ff, axial_in;

   // stage 2: finished distance
   logic                s2_valid_ff;
   ppsc_pkg::entry_type s2_entry_ff, s2_entry_in;

   logic signed [ppsc_pkg::DIST_W-1:0] term_x, term_y, term_z, offset_ext;

   assign s1_valid_in = accept;
   assign prod_x_in   = $signed(req.point_x) * $signed(cfg.normal_x);
   assign prod_y_in   = $signed(req.point_y) * $signed(cfg.normal_y);
   assign prod_z_in   = $signed(req.point_z) * $signed(cfg.normal_z);

   always_comb begin
      unique case (cfg.plane_kind)
         ppsc_pkg::KIND_AXIAL_X: axial_in = req.point_x;
         ppsc_pkg::KIND_AXIAL_Y: axial_in = req.point_y;
         ppsc_pkg::KIND_AXIAL_Z: axial_in = req.point_z;
         ppsc_pkg::KIND_SLOPED:  axial_in = req.point_x;
      endcase
   end

   // arithmetic shift of the q.42 product is a floor to q.12
   assign term_x     = {{6{prod_x_ff[63]}}, prod_x_ff[63:30]};
   assign term_y     = {{6{prod_y_ff[63]}}, prod_y_ff[63:30]};
   assign term_z     = {{6{prod_z_ff[63]}}, prod_z_ff[63:30]};
   assign offset_ext = {{8{cfg.plane_offset[31]}}, cfg.plane_offset};

   always_comb begin
      s2_entry_in.last_point = s1_last_ff;
      if (cfg.plane_kind == ppsc_pkg::KIND_SLOPED) begin
         s2_entry_in.distance = term_x + term_y + term_z - offset_ext;
      end else begin
         s2_entry_in.distance = {{8{axial_ff[31]}}, axial_ff} - offset_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      prod_z_ff   <= prod_z_in;
      axial_ff    <= axial_in;
      s1_last_ff  <= req.last_point;
      s2_entry_ff <= s2_entry_in;
   end

   assign push            = s2_valid_ff;
   assign push_entry      = s2_entry_ff;
   assign status.s1_valid = s1_valid_ff;
   assign status.s2_valid = s2_valid_ff;

endmodule

@@ rtl/ppsc_queue.sv @@
// small register fifo of distance words between front and back parts
// depends on ppsc_pkg
`timescale 1ns / 1ps

module ppsc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  ppsc_pkg::entry_type         push_entry,
   input  logic                        pop,
   output ppsc_pkg::entry_type         head,
   output logic                        not_empty,
   output logic [$clog2(DEPTH+1)-1:0]  level
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   ppsc_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head      = entries_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign level     = count_ff;

endmodule

@@ rtl/ppsc_back.sv @@
// back part: running extremes, classification and result register
// depends on ppsc_pkg
`timescale 1ns / 1ps

module ppsc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ppsc_pkg::cfg_type    cfg,
   input  ppsc_pkg::entry_type  head,
   input  logic                 not_empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ppsc_pkg::rsp_type    rsp_payload
);

   localparam int W = ppsc_pkg::DIST_W;

   logic signed [W-1:0] front_ff, front_in, back_ff, back_in;
   logic signed [W-1:0] front_new, back_new;
   logic signed [W-1:0] chop_e, min_e, max_e;
   logic                rsp_valid_ff, rsp_valid_in;
   ppsc_pkg::rsp_type   rsp_ff, rsp_in, verdict;

   assign pop = not_empty && (!rsp_valid_ff || rsp_ready);

   assign front_new = (head.distance > front_ff) ? head.distance : front_ff;
   assign back_new  = (head.distance < back_ff)  ? head.distance : back_ff;

   assign chop_e = {{(W-31){1'b0}}, cfg.chop_margin};
   assign min_e  = {{(W-31){1'b0}}, cfg.min_split_margin};
   assign max_e  = {{(W-31){1'b0}}, cfg.max_split_margin};

   always_comb begin
      priority if (front_new <= chop_e) begin
         verdict.side       = ppsc_pkg::SIDE_BEHIND;
         verdict.near_split = (front_new > min_e) || (back_new > -max_e);
      end else if (back_new >= -chop_e) begin
         verdict.side       = ppsc_pkg::SIDE_AHEAD;
         verdict.near_split = (back_new < -min_e) || (front_new < max_e);
      end else begin
         verdict.side       = ppsc_pkg::SIDE_CROSS;
         verdict.near_split = (front_new < max_e) || (back_new > -max_e);
      end
   end

   always_comb begin
      front_in     = front_ff;
      back_in      = back_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop) begin
         if (head.last_point) begin
            front_in     = '0;
            back_in      = '0;
            rsp_in       = verdict;
            rsp_valid_in = 1'b1;
         end else begin
            front_in = front_new;
            back_in  = back_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         back_ff      <= back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/polygon_plane_side_classifier_unit.sv @@
// top level of the polygon plane side classifier
// depends on ppsc_pkg, ppsc_csr, ppsc_front, ppsc_queue, ppsc_back and the assert header
`timescale 1ns / 1ps

// takes one polygon vertex per word on req_ and returns one word on rsp_ for
// each vertex marked last_point: side (front, back or crossing against the
// configured plane, decided with chop_margin) and near_split. vertices stream
// at one word per clock unless the result channel stalls; the rate is set by
// the back part's single-cycle max/min update, and a queue of QUEUE_DEPTH words
// (4 or more for full rate) covers the two-stage distance pipeline in front of
// it. a result passes the distance stages, queue and result register after
// its last vertex is taken; the next polygon may follow directly. configuration goes
// through the apb port; the user writes it only while the block is idle (not enforced).
`include "polygon_plane_side_classifier_unit_assert.svh"

module polygon_plane_side_classifier_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   // vertex word channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  ppsc_pkg::req_type            req_payload,
   // result word channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ppsc_pkg::rsp_type            rsp_payload,
   // configuration port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ppsc_pkg::ADDR_W-1:0]  paddr,
   input  logic [ppsc_pkg::DATA_W-1:0]  pwdata,
   output logic [ppsc_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ppsc_pkg::cfg_type           cfg;
   ppsc_pkg::front_status_type  front_status;
   ppsc_pkg::entry_type         push_entry, head;
   logic                        push, pop, not_empty, req_accept;
   logic [CNT_W-1:0]            level;
   logic [CNT_W:0]              used;

   // credit check: queued words plus those still in the pipeline
   assign used = {1'b0, level} + (CNT_W+1)'(front_status.s1_valid)
                 + (CNT_W+1)'(front_status.s2_valid);
   assign req_ready  = (used < (CNT_W+1)'(QUEUE_DEPTH));
   assign req_accept = req_valid && req_ready;

   ppsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // front: distance to the plane, two stages, never stalls
   ppsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .req        (req_payload),
      .cfg        (cfg),
      .push       (push),
      .push_entry (push_entry),
      .status     (front_status)
   );

   ppsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .level      (level)
   );

   // back: extremes and verdict, stalls on the result channel only
   ppsc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .head        (head),
      .not_empty   (not_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // credits never exceed the queue
   `PPSC_ASSERT_ALWAYS(a_credit_bound, clock, reset, used <= (CNT_W+1)'(QUEUE_DEPTH))
   // a push into a full queue needs a pop in the same cycle
   `PPSC_ASSERT_IMPLY(a_no_overflow, clock, reset, push && (level == CNT_W'(QUEUE_DEPTH)), pop)
   // the back part only takes words that are there
   `PPSC_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, level != '0)

endmodule

@@ test/tb.sv @@
// self-checking testbench for polygon_plane_side_classifier_unit
// depends on ppsc_pkg and the rtl of the block; predicts every result word itself
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int LONG_HOLD    = 300;

   // tracks the running distance extremes of the open polygon and keeps the
   // side words that the block owes us, oldest first
   class polygon_side_checker;
      ppsc_pkg::cfg_type regs;
      longint            front_peak;
      longint            back_peak;
      ppsc_pkg::rsp_type expected_sides[$];
      int                mismatches;

      function new();
         regs.normal_x         = ppsc_pkg::RST_NORMAL_X;
         regs.normal_y         = ppsc_pkg::RST_NORMAL_Y;
         regs.normal_z         = ppsc_pkg::RST_NORMAL_Z;
         regs.plane_offset     = ppsc_pkg::RST_OFFSET;
         regs.plane_kind       = ppsc_pkg::RST_KIND;
         regs.chop_margin      = ppsc_pkg::RST_CHOP;
         regs.min_split_margin = ppsc_pkg::RST_MIN_SPLIT;
         regs.max_split_margin = ppsc_pkg::RST_MAX_SPLIT;
         front_peak = 0;
         back_peak  = 0;
         mismatches = 0;
      endfunction

      function void set_register(input logic [2:0] idx, input logic [31:0] data);
         case (idx)
            ppsc_pkg::REG_NORMAL_X:  regs.normal_x         = data;
            ppsc_pkg::REG_NORMAL_Y:  regs.normal_y         = data;
            ppsc_pkg::REG_NORMAL_Z:  regs.normal_z         = data;
            ppsc_pkg::REG_OFFSET:    regs.plane_offset     = data;
            ppsc_pkg::REG_KIND:      regs.plane_kind       = data[1:0];
            ppsc_pkg::REG_CHOP:      regs.chop_margin      = data[30:0];
            ppsc_pkg::REG_MIN_SPLIT: regs.min_split_margin = data[30:0];
            ppsc_pkg::REG_MAX_SPLIT: regs.max_split_margin = data[30:0];
            default: ;
         endcase
      endfunction

      // signed Q.12 distance of one vertex; sloped terms are floored one by one
      function longint plane_distance(input ppsc_pkg::req_type v);
         longint px, py, pz, off;
         px  = longint'($signed(v.point_x));
         py  = longint'($signed(v.point_y));
         pz  = longint'($signed(v.point_z));
         off = longint'($signed(regs.plane_offset));
         case (regs.plane_kind)
            ppsc_pkg::KIND_AXIAL_X: return px - off;
            ppsc_pkg::KIND_AXIAL_Y: return py - off;
            ppsc_pkg::KIND_AXIAL_Z: return pz - off;
            default: return ((px * longint'($signed(regs.normal_x))) >>> 30)
                          + ((py * longint'($signed(regs.normal_y))) >>> 30)
                          + ((pz * longint'($signed(regs.normal_z))) >>> 30) - off;
         endcase
      endfunction

      function void note_vertex(input ppsc_pkg::req_type v);
         longint            d, chop, lo, hi;
         ppsc_pkg::rsp_type w;
         d = plane_distance(v);
         if (d > front_peak) front_peak = d;
         if (d < back_peak) back_peak = d;
         if (!v.last_point) return;
         chop = regs.chop_margin;
         lo   = regs.min_split_margin;
         hi   = regs.max_split_margin;
         if (front_peak <= chop) begin
            w.side       = ppsc_pkg::SIDE_BEHIND;
            w.near_split = (front_peak > lo) || (back_peak > -hi);
         end else if (back_peak >= -chop) begin
            w.side       = ppsc_pkg::SIDE_AHEAD;
            w.near_split = (back_peak < -lo) || (front_peak < hi);
         end else begin
            w.side       = ppsc_pkg::SIDE_CROSS;
            w.near_split = (front_peak < hi) || (back_peak > -hi);
         end
         expected_sides.push_back(w);
         front_peak = 0;
         back_peak  = 0;
      endfunction

      function void check_word(input ppsc_pkg::rsp_type got);
         ppsc_pkg::rsp_type want;
         if (expected_sides.size() == 0) begin
            $error("result word with nothing expected: side %0d near_split %0d",
                   got.side, got.near_split);
            mismatches++;
            return;
         end
         want = expected_sides.pop_front();
         if (got.side !== want.side) begin
            $error("side: expected %0d, actual %0d", want.side, got.side);
            mismatches++;
         end
         if (got.near_split !== want.near_split) begin
            $error("near_split: expected %0d, actual %0d", want.near_split, got.near_split);
            mismatches++;
         end
      endfunction
   endclass

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_ready;
   ppsc_pkg::req_type             req_payload = '0;
   logic                          rsp_valid;
   logic                          rsp_ready   = 1'b0;
   ppsc_pkg::rsp_type             rsp_payload;
   logic                          psel        = 1'b0;
   logic                          penable     = 1'b0;
   logic                          pwrite      = 1'b0;
   logic [ppsc_pkg::ADDR_W-1:0]   paddr       = '0;
   logic [ppsc_pkg::DATA_W-1:0]   pwdata      = '0;
   logic [ppsc_pkg::DATA_W-1:0]   prdata;
   logic                          pready;

   polygon_side_checker sb;
   int                  cycle_count  = 0;
   int                  coord_center = 0;
   bit                  sender_calm  = 1'b0;
   bit                  hold_results = 1'b0;
   int                  hold_left    = 0;
   int                  calm_left    = 0;
   int                  roll;

   polygon_plane_side_classifier_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #5 clock = ~clock;

   // run limit, well above the slowest legal run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result words are checked at the edge that takes them
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_word(rsp_payload);
   end

   // receiver: short random stalls, a few long ones, calm stretches, and one
   // long hold-off on request so the block backs up into its input
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_results) begin
         hold_results = 1'b0;
         hold_left    = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (calm_left > 0) begin
         rsp_ready <= 1'b1;
         calm_left--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            calm_left = $urandom_range(20, 80);
            rsp_ready <= 1'b1;
         end else if (roll < 70) begin
            rsp_ready <= 1'b1;
         end else if (roll < 95) begin
            hold_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            hold_left = $urandom_range(8, 30);
            rsp_ready <= 1'b0;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (sender_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // mostly near the plane so all three sides and both flags show up
   function automatic logic [31:0] pick_coord();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return coord_center + int'($urandom_range(0, 24575)) - 12288;
   endfunction

   function automatic logic [30:0] pick_margin();
      if ($urandom_range(0, 5) == 0) return 31'($urandom);
      return 31'($urandom_range(0, 8192));
   endfunction

   function automatic ppsc_pkg::req_type make_vertex(input logic [31:0] x, y, z,
                                                     input logic last);
      ppsc_pkg::req_type v;
      v.point_x    = x;
      v.point_y    = y;
      v.point_z    = z;
      v.last_point = last;
      return v;
   endfunction

   // offers one vertex word; valid stays up into the next word when no gap
   task automatic send_vertex(input ppsc_pkg::req_type v);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= v;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_vertex(v);
   endtask

   task automatic send_random_items(input int n, input bit singles);
      int                left, len, k;
      ppsc_pkg::req_type v;
      left = n;
      while (left > 0) begin
         if (singles) len = 1;
         else if ($urandom_range(0, 3) == 0) len = $urandom_range(5, 12);
         else len = $urandom_range(1, 4);
         if (len > left) len = left;
         for (k = 0; k < len; k++) begin
            v = make_vertex(pick_coord(), pick_coord(), pick_coord(), k == len - 1);
            send_vertex(v);
         end
         left -= len;
      end
   endtask

   // sender goes quiet until every owed word is back, then lets the pipe settle
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_sides.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // writes every register; margins get a random spare top bit
   task automatic load_plane(input logic [31:0] nx, ny, nz, off, input logic [1:0] kind,
                             input logic [30:0] chop, lo, hi);
      wait_drained();
      write_reg(ppsc_pkg::REG_NORMAL_X, nx);
      write_reg(ppsc_pkg::REG_NORMAL_Y, ny);
      write_reg(ppsc_pkg::REG_NORMAL_Z, nz);
      write_reg(ppsc_pkg::REG_OFFSET, off);
      write_reg(ppsc_pkg::REG_KIND, {30'd0, kind});
      write_reg(ppsc_pkg::REG_CHOP, {1'($urandom), chop});
      write_reg(ppsc_pkg::REG_MIN_SPLIT, {1'($urandom), lo});
      write_reg(ppsc_pkg::REG_MAX_SPLIT, {1'($urandom), hi});
      coord_center = (kind == ppsc_pkg::KIND_SLOPED) ? 0 : int'(off);
   endtask

   function automatic logic [31:0] pick_normal();
      return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
   endfunction

   function automatic logic [31:0] pick_offset();
      return 32'($urandom_range(0, 65535)) - 32'd32768;
   endfunction

   initial begin
      int p;
      sb = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset plane: sloped, normal along x, so distance is just x
      send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 1'b1));                    // on the plane
      send_vertex(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
      send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
      send_vertex(make_vertex(32'd8192, 32'h0, 32'h0, 1'b0));                 // crossing pair
      send_vertex(make_vertex(-32'sd8192, 32'h0, 32'h0, 1'b1));
      send_vertex(make_vertex(32'd2, 32'h8000_0000, 32'h8000_0000, 1'b1));    // inside chop
      send_vertex(make_vertex(32'd3000, 32'h0, 32'h0, 1'b1));                 // front, near
      send_vertex(make_vertex(32'd5, 32'h0, 32'h0, 1'b1));                    // just past chop
      send_vertex(make_vertex(-32'sd5000, 32'h0, 32'h0, 1'b0));
      send_vertex(make_vertex(32'd100, 32'h0, 32'h0, 1'b0));
      send_vertex(make_vertex(32'd5, 32'h0, 32'h0, 1'b1));
      send_vertex(make_vertex(32'd1, 32'hFFFF_FFFF, 32'h5555_5555, 1'b0));
      send_vertex(make_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
      send_vertex(make_vertex(-32'sd4, 32'h0, 32'h0, 1'b1));                  // back, edge
      send_random_items(60, 1'b0);

      // axial planes; normals must have no effect
      load_plane(pick_normal(), pick_normal(), pick_normal(), 32'h0, ppsc_pkg::KIND_AXIAL_X,
                 31'd4, 31'd4, 31'd4096);
      send_random_items(60, 1'b0);

      // offset at its top, all margins zero, sender with no gaps
      load_plane(pick_normal(), pick_normal(), pick_normal(), 32'h7FFF_FFFF,
                 ppsc_pkg::KIND_AXIAL_Y, 31'd0, 31'd0, 31'd0);
      sender_calm = 1'b1;
      send_random_items(60, 1'b0);
      sender_calm = 1'b0;

      // offset at its bottom, all margins at their top
      load_plane(pick_normal(), pick_normal(), pick_normal(), 32'h8000_0000,
                 ppsc_pkg::KIND_AXIAL_Z, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_random_items(60, 1'b0);

      // sloped plane with normals beyond +-1.0 and one at -1.0
      load_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'hC000_0000, pick_offset(),
                 ppsc_pkg::KIND_SLOPED, pick_margin(), pick_margin(), pick_margin());
      send_vertex(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
      send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
      send_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0));
      send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 1'b1));
      send_vertex(make_vertex(32'h1, 32'hFFFF_FFFF, 32'h5555_5555, 1'b1));

      // long receiver hold-off while one-vertex polygons keep coming
      hold_results = 1'b1;
      sender_calm  = 1'b1;
      send_random_items(40, 1'b1);
      sender_calm  = 1'b0;
      send_random_items(60, 1'b0);

      // all normals at -1.0
      load_plane(32'hC000_0000, 32'hC000_0000, 32'hC000_0000, 32'h0, ppsc_pkg::KIND_SLOPED,
                 pick_margin(), pick_margin(), pick_margin());
      send_random_items(60, 1'b0);

      // random planes of every kind
      for (p = 0; p < 4; p++) begin
         load_plane(pick_normal(), pick_normal(), pick_normal(), pick_offset(),
                    2'($urandom_range(0, 3)), pick_margin(), pick_margin(), pick_margin());
         sender_calm = (p == 2);
         send_random_items(60, 1'b0);
      end
      sender_calm = 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_sides.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ppsc_pkg.sv
rtl/ppsc_csr.sv
rtl/ppsc_front.sv
rtl/ppsc_queue.sv
rtl/ppsc_back.sv
rtl/polygon_plane_side_classifier_unit.sv
test/tb.sv
